@@ sv/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// SVPWM package
// Shared types, fixed-point constants and sector decode for the modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int QUARTER_BITS = ANGLE_BITS - 2;
	localparam int TFB          = 15;                 // time fraction bits
	localparam int N_W          = 58;                 // signed numerator width
	localparam int D_W          = 59;                 // unsigned divisor width
	localparam int DIV_LAT      = TFB + 1;            // divider stages
	localparam int LAT          = 14 + DIV_LAT;       // request to result

	localparam logic [TFB:0]   TIME_ONE  = (TFB+1)'(1) << TFB;
	localparam logic [TFB-1:0] TIME_HALF = TFB'(1) << (TFB - 1);

	localparam logic [16:0] SIN_A = 17'd51472;
	localparam logic [14:0] SIN_B = 15'd21024;
	localparam logic [11:0] SIN_C = 12'd2320;
	localparam logic signed [17:0] SQRT3_Q15 = 18'sd56756;

	localparam logic CFG_SUPPLY = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	localparam logic [14:0] SUPPLY_RST = 15'd12288;
	localparam logic [15:0] PERIOD_RST = 16'd1000;

	typedef struct packed {
		logic signed [15:0] torque_voltage;
		logic signed [15:0] direct_voltage;
		logic [15:0]        rotor_angle;
	} req_t;

	typedef struct packed {
		logic [15:0] compare_a;
		logic [15:0] compare_b;
		logic [15:0] compare_c;
		logic [2:0]  sector_number;
	} rsp_t;

	// Map the three sign tests to a sector; empty codes fall back to sector 1.
	function automatic logic [2:0] sector_of(input logic [2:0] code);
		logic [2:0] s;
		case (code)
			3'd1: s = 3'd2;
			3'd2: s = 3'd6;
			3'd3: s = 3'd1;
			3'd4: s = 3'd4;
			3'd5: s = 3'd3;
			3'd6: s = 3'd5;
			default: s = 3'd1;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ sv/svpwm_sin.sv @@
// ----------------------------------------------------------------------------
// SVPWM sine unit
// Five-stage polynomial sine of a turn angle, signed Q2.15 result.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sin (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] angle,
	output logic signed [17:0] sine
);

	localparam int ANGLE_MSB = svpwm_pkg::ANGLE_BITS - 1;

	logic [1:0]  quad;
	logic [14:0] r_w;
	logic [15:0] z_w;

	logic [15:0] z_s1, z_s2, z_s3, z_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [15:0] z2_s2, z2_s3;
	logic [14:0] t_s3;
	logic [16:0] t_s4;

	logic [31:0] zz_w;
	logic [27:0] cz_w;
	logic [30:0] tz_w;
	logic [32:0] sz_w;

	assign quad = angle[ANGLE_MSB -: 2];
	assign r_w  = 15'({angle[svpwm_pkg::QUARTER_BITS-1:0], 1'b0});
	assign z_w  = quad[0] ? (16'd32768 - {1'b0, r_w}) : {1'b0, r_w};

	assign zz_w = z_s1 * z_s1;
	assign cz_w = svpwm_pkg::SIN_C * z2_s2;
	assign tz_w = t_s3 * z2_s3;
	assign sz_w = t_s4 * z_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= z_w;
			neg_s1 <= quad[1];

			z_s2   <= z_s1;
			neg_s2 <= neg_s1;
			z2_s2  <= zz_w[30:15];

			z_s3   <= z_s2;
			neg_s3 <= neg_s2;
			z2_s3  <= z2_s2;
			t_s3   <= svpwm_pkg::SIN_B - 15'(cz_w >> 15);

			z_s4   <= z_s3;
			neg_s4 <= neg_s3;
			t_s4   <= svpwm_pkg::SIN_A - 17'(tz_w >> 15);

			sine   <= neg_s4 ? -$signed({1'b0, sz_w[31:15]}) : $signed({1'b0, sz_w[31:15]});
		end
	end

endmodule

`default_nettype wire

@@ sv/svpwm_div.sv @@
// ----------------------------------------------------------------------------
// SVPWM ratio divider
// Pipelined restoring divider: floor(num*ONE/den) clamped to [0, ONE].
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_div (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [svpwm_pkg::N_W-1:0] num,
	input  wire logic [svpwm_pkg::D_W-1:0]        den,
	output logic [svpwm_pkg::TFB:0]               quo
);

	localparam int TFB = svpwm_pkg::TFB;
	localparam int D_W = svpwm_pkg::D_W;

	logic [D_W:0]   rem_s [TFB+1];
	logic [D_W-1:0] den_s [TFB+1];
	logic [TFB-1:0] q_s   [TFB+1];
	logic           zero_s[TFB+1];
	logic           one_s [TFB+1];

	logic [D_W:0]   rem_w [TFB];
	logic [TFB-1:0] q_w   [TFB];

	// One quotient bit per stage.
	always_comb begin
		for (int k = 0; k < TFB; k++) begin
			if ({rem_s[k][D_W-1:0], 1'b0} >= {1'b0, den_s[k]}) begin
				rem_w[k] = {rem_s[k][D_W-1:0], 1'b0} - {1'b0, den_s[k]};
				q_w[k]   = {q_s[k][TFB-2:0], 1'b1};
			end else begin
				rem_w[k] = {rem_s[k][D_W-1:0], 1'b0};
				q_w[k]   = {q_s[k][TFB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= (D_W+1)'(unsigned'(num));
			den_s[0]  <= den;
			q_s[0]    <= '0;
			zero_s[0] <= (num <= 0);
			one_s[0]  <= (num >= $signed({1'b0, den}));
			for (int k = 1; k <= TFB; k++) begin
				rem_s[k]  <= rem_w[k-1];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= q_w[k-1];
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
			end
		end
	end

	assign quo = zero_s[TFB] ? '0 :
	             one_s[TFB]  ? svpwm_pkg::TIME_ONE : {1'b0, q_s[TFB]};

endmodule

`default_nettype wire

@@ sv/svpwm_seven_segment_modulator_top.sv @@
// ----------------------------------------------------------------------------
// Seven-segment SVPWM modulator
// Turns a dq voltage request and an electrical angle into three compares.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries torque voltage,
//   direct voltage and angle; response channel (rsp_valid/rsp_ready/rsp_data)
//   returns compare_a/b/c and the sector, one response per request, in order.
//   Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) set the bus
//   voltage (index 0) and the timer period (index 1); cfg_ready is always high.
//   Write configuration only while no request is in flight.
//   The pipeline has 30 register stages and takes one request every cycle
//   unless the output stalls; new requests enter before earlier ones leave.
//   The stage count is set by the five-stage sine unit, the dq-to-sector chain
//   and the 16-stage divider, one quotient bit in each stage after the first.
//   Reset clears all valid bits and loads the default bus voltage and period.
//   When the receiver holds rsp_ready low with a response waiting, the whole
//   pipeline holds and req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_seven_segment_modulator_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire svpwm_pkg::req_t   req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output svpwm_pkg::rsp_t        rsp_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data
);

	localparam int LAT     = svpwm_pkg::LAT;
	localparam int N_W     = svpwm_pkg::N_W;
	localparam int D_W     = svpwm_pkg::D_W;
	localparam int TFB     = svpwm_pkg::TFB;
	localparam int DIV_LAT = svpwm_pkg::DIV_LAT;

	// Configuration registers.
	logic [14:0] supply_q;
	logic [15:0] period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= svpwm_pkg::SUPPLY_RST;
			period_q <= svpwm_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				svpwm_pkg::CFG_SUPPLY: supply_q <= cfg_data[14:0];
				svpwm_pkg::CFG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: hold every stage while a response waits unread.
	logic adv;
	logic [LAT:1] valid_s;

	assign adv       = !valid_s[LAT] || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = valid_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[LAT-1:1], req_valid};
		end
	end

	// Stage 0: fold a negative q voltage into a half-turn shift.
	logic        uq_neg;
	logic [16:0] uq_mag;
	logic [15:0] ang_sin, ang_cos;

	assign uq_neg  = req_data.torque_voltage[15];
	assign uq_mag  = uq_neg ? (17'd0 - {1'b1, req_data.torque_voltage})
	                        : {1'b0, req_data.torque_voltage};
	assign ang_sin = req_data.rotor_angle ^ {uq_neg, 15'd0};
	assign ang_cos = ang_sin + (16'd1 << svpwm_pkg::QUARTER_BITS);

	logic signed [17:0] sn_w, cs_w;

	svpwm_sin u_sin (.clk(clk), .en(adv), .angle(ang_sin), .sine(sn_w));
	svpwm_sin u_cos (.clk(clk), .en(adv), .angle(ang_cos), .sine(cs_w));

	// Carry the voltages alongside the sine unit.
	logic signed [15:0] ud_s [1:5];
	logic [16:0]        uq_s [1:5];

	always_ff @(posedge clk) begin
		if (adv) begin
			ud_s[1] <= req_data.direct_voltage;
			uq_s[1] <= uq_mag;
			for (int k = 2; k <= 5; k++) begin
				ud_s[k] <= ud_s[k-1];
				uq_s[k] <= uq_s[k-1];
			end
		end
	end

	// Stage 6: inverse Park products. Stage 7: alpha and beta.
	logic signed [17:0] uqs_w;
	logic signed [35:0] p_dc_s6, p_qs_s6, p_ds_s6, p_qc_s6;
	logic signed [36:0] alpha_s7, beta_s7;

	assign uqs_w = $signed({1'b0, uq_s[5]});

	always_ff @(posedge clk) begin
		if (adv) begin
			p_dc_s6  <= ud_s[5] * cs_w;
			p_qs_s6  <= uqs_w * sn_w;
			p_ds_s6  <= ud_s[5] * sn_w;
			p_qc_s6  <= uqs_w * cs_w;
			alpha_s7 <= p_dc_s6 - p_qs_s6;
			beta_s7  <= p_ds_s6 + p_qc_s6;
		end
	end

	// Stage 8: scale by sqrt(3).
	logic signed [54:0] s3a_s8, bs3_s8;
	logic signed [36:0] alpha_s8, beta_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			s3a_s8   <= alpha_s7 * svpwm_pkg::SQRT3_Q15;
			bs3_s8   <= beta_s7 * svpwm_pkg::SQRT3_Q15;
			alpha_s8 <= alpha_s7;
			beta_s8  <= beta_s7;
		end
	end

	// Stage 9: sector from the three sign tests.
	logic signed [55:0] bq_w, tb_w, tc_w;
	logic [2:0]         code_w;
	logic [2:0]         sec_s9;
	logic signed [36:0] alpha_s9;
	logic signed [54:0] bs3_s9;

	assign bq_w   = 56'(beta_s8) <<< 15;
	assign tb_w   = 56'(s3a_s8) - bq_w;
	assign tc_w   = -56'(s3a_s8) - bq_w;
	assign code_w = {(tc_w > 0), (tb_w > 0), (beta_s8 > 0)};

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s9   <= svpwm_pkg::sector_of(code_w);
			alpha_s9 <= alpha_s8;
			bs3_s9   <= bs3_s8;
		end
	end

	// Stage 10: numerators of T1 and T2 for the chosen sector.
	logic signed [N_W-1:0] a3_w, b1_w, b2_w, n1_w, n2_w;
	logic signed [N_W-1:0] n1_s10, n2_s10;
	logic [2:0]            sec_s10;

	assign a3_w = (N_W'(alpha_s9) <<< 15) + (N_W'(alpha_s9) <<< 16);
	assign b1_w = N_W'(bs3_s9);
	assign b2_w = N_W'(bs3_s9) <<< 1;

	always_comb begin
		case (sec_s9)
			3'd1: begin n1_w = a3_w - b1_w;  n2_w = b2_w;         end
			3'd2: begin n1_w = a3_w + b1_w;  n2_w = b1_w - a3_w;  end
			3'd3: begin n1_w = b2_w;         n2_w = -b1_w - a3_w; end
			3'd4: begin n1_w = b1_w - a3_w;  n2_w = -b2_w;        end
			3'd5: begin n1_w = -a3_w - b1_w; n2_w = a3_w - b1_w;  end
			default: begin n1_w = -b2_w;     n2_w = b1_w + a3_w;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s10  <= n1_w;
			n2_s10  <= n2_w;
			sec_s10 <= sec_s9;
		end
	end

	// Stage 11: pick the divisor; overmodulation divides by n1+n2.
	logic [14:0]           vdc_w;
	logic signed [D_W:0]   sum_w, lim_w;
	logic signed [N_W-1:0] n1_s11, n2_s11;
	logic [D_W-1:0]        den_s11;
	logic [2:0]            sec_s11;

	assign vdc_w = (supply_q == '0) ? 15'd1 : supply_q;
	assign sum_w = (D_W+1)'(n1_s10) + (D_W+1)'(n2_s10);
	assign lim_w = $signed({1'b0, (D_W)'({vdc_w, 31'd0})});

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s11  <= n1_s10;
			n2_s11  <= n2_s10;
			den_s11 <= (sum_w > lim_w) ? sum_w[D_W-1:0] : lim_w[D_W-1:0];
			sec_s11 <= sec_s10;
		end
	end

	// Stages 12 to 27: two ratio dividers.
	logic [TFB:0] t1_w, t2_w;
	logic [2:0]   sec_dv_s [DIV_LAT];

	svpwm_div u_div1 (.clk(clk), .en(adv), .num(n1_s11), .den(den_s11), .quo(t1_w));
	svpwm_div u_div2 (.clk(clk), .en(adv), .num(n2_s11), .den(den_s11), .quo(t2_w));

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_dv_s[0] <= sec_s11;
			for (int k = 1; k < DIV_LAT; k++) begin
				sec_dv_s[k] <= sec_dv_s[k-1];
			end
		end
	end

	// Stage 28: zero-vector time and seven-segment duties.
	logic [TFB+1:0] tsum_w, h_w, da_w, db_w, dc_w;
	logic [TFB:0]   t0_w;
	logic [TFB+1:0] da_s28, db_s28, dc_s28;
	logic [2:0]     sec_s28;

	assign tsum_w = (TFB+2)'(t1_w) + (TFB+2)'(t2_w);
	assign t0_w   = (tsum_w >= (TFB+2)'(svpwm_pkg::TIME_ONE)) ? '0
	                : (TFB+1)'((TFB+2)'(svpwm_pkg::TIME_ONE) - tsum_w);
	assign h_w    = (TFB+2)'(t0_w >> 1);

	always_comb begin
		case (sec_dv_s[DIV_LAT-1])
			3'd1: begin da_w = h_w;          db_w = h_w + t1_w;   dc_w = h_w + tsum_w; end
			3'd2: begin da_w = h_w + t2_w;   db_w = h_w;          dc_w = h_w + tsum_w; end
			3'd3: begin da_w = h_w + tsum_w; db_w = h_w;          dc_w = h_w + t1_w;   end
			3'd4: begin da_w = h_w + tsum_w; db_w = h_w + t2_w;   dc_w = h_w;          end
			3'd5: begin da_w = h_w + t1_w;   db_w = h_w + tsum_w; dc_w = h_w;          end
			default: begin da_w = h_w;       db_w = h_w + tsum_w; dc_w = h_w + t2_w;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_s28  <= da_w;
			db_s28  <= db_w;
			dc_s28  <= dc_w;
			sec_s28 <= sec_dv_s[DIV_LAT-1];
		end
	end

	// Stage 29: clamp duty to one, scale by the period with half-up rounding.
	function automatic logic [TFB:0] clamp_one(input logic [TFB+1:0] d);
		return (d > (TFB+2)'(svpwm_pkg::TIME_ONE)) ? svpwm_pkg::TIME_ONE : d[TFB:0];
	endfunction

	logic [TFB+17:0] pa_s29, pb_s29, pc_s29;
	logic [2:0]      sec_s29;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s29  <= clamp_one(da_s28) * period_q + (TFB+18)'(svpwm_pkg::TIME_HALF);
			pb_s29  <= clamp_one(db_s28) * period_q + (TFB+18)'(svpwm_pkg::TIME_HALF);
			pc_s29  <= clamp_one(dc_s28) * period_q + (TFB+18)'(svpwm_pkg::TIME_HALF);
			sec_s29 <= sec_s28;
		end
	end

	// Stage 30: drop the fraction and clamp to the period.
	function automatic logic [15:0] to_cmp(input logic [TFB+17:0] p, input logic [15:0] per);
		logic [17:0] c;
		c = 18'(p >> TFB);
		return (c > {2'b00, per}) ? per : c[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data.compare_a     <= to_cmp(pa_s29, period_q);
			rsp_data.compare_b     <= to_cmp(pb_s29, period_q);
			rsp_data.compare_c     <= to_cmp(pc_s29, period_q);
			rsp_data.sector_number <= sec_s29;
		end
	end

endmodule

`default_nettype wire

@@ sv/svpwm_chk.sv @@
// ----------------------------------------------------------------------------
// SVPWM port checker
// Port-level properties of the modulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_chk (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_ready,
	input  wire logic            rsp_valid,
	input  wire logic            rsp_ready,
	input  wire svpwm_pkg::rsp_t rsp_data
);

	// Hold a stalled response.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.sector_number >= 3'd1 && rsp_data.sector_number <= 3'd6))
		else $error("sector out of range");

	// Requests are refused only while a response sits unread.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without output stall");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken during output stall");

endmodule

bind svpwm_seven_segment_modulator_top svpwm_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data(rsp_data)
);

`default_nettype wire

@@ tb/sv/svpwm_seven_segment_modulator_top_tb.sv @@
// ----------------------------------------------------------------------------
// Seven-segment SVPWM modulator testbench
// Drives dq voltage requests with random gaps and response stalls, predicts
// compares and sector in fixed point, and checks every response in order.
// Bus voltage and period are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_seven_segment_modulator_top_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	svpwm_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	svpwm_pkg::rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = svpwm_pkg::CFG_SUPPLY;
	logic [15:0] cfg_data = '0;

	svpwm_seven_segment_modulator_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the two registers
	longint bus_volts = 12288;
	longint period = 1000;

	svpwm_pkg::req_t pending_reqs[$];
	svpwm_pkg::rsp_t expected_compares[$];
	int errors = 0;
	bit stim_done = 1'b0;

	// Cfg write queue: {index, data}; not used, writes go through write_reg
	logic [16:0] pending_cfg[$];

	task automatic report(input string what, input svpwm_pkg::rsp_t got,
			input svpwm_pkg::rsp_t want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// Polynomial sine over one quarter turn, z in Q15
	function automatic longint quarter_sin(input longint z);
		longint z2, t;
		z2 = (z * z) >>> 15;
		t = (2320 * z2) >>> 15;
		t = 21024 - t;
		t = (t * z2) >>> 15;
		t = 51472 - t;
		return (t * z) >>> 15;
	endfunction

	function automatic longint turn_sin(input logic [15:0] a);
		logic [1:0] quad;
		longint z, s;
		quad = a[15:14];
		z = longint'(a[13:0]) << 1;
		if (quad[0]) z = 32768 - z;
		s = quarter_sin(z);
		return quad[1] ? -s : s;
	endfunction

	// floor(n*ONE/d) clamped to [0, ONE]
	function automatic longint time_ratio(input longint n, input longint d);
		longint rem, q;
		if (n <= 0) return 0;
		if (n >= d) return 32768;
		rem = n;
		q = 0;
		for (int i = 0; i < 15; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= d) begin
				rem -= d;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] duty_to_compare(input longint duty);
		longint c;
		if (duty > 32768) duty = 32768;
		c = (duty * period + 16384) >>> 15;
		if (c > period) c = period;
		return c[15:0];
	endfunction

	function automatic svpwm_pkg::rsp_t predict_compares(input svpwm_pkg::req_t r);
		longint uq, ud, sn, cs, al, be, s3a, n1, n2, dv, t1, t2, t0, h;
		longint da, db, dc;
		longint st[7], ct[7];
		logic [15:0] ang;
		logic [2:0] code, sec;
		svpwm_pkg::rsp_t o;
		st = '{0, 3, 3, 0, -3, -3, 0};
		ct = '{2, 1, -1, -2, -1, 1, 2};
		uq = r.torque_voltage;
		ud = r.direct_voltage;
		ang = r.rotor_angle;
		if (uq < 0) begin
			ang = ang + 16'h8000;
			uq = -uq;
		end
		sn = turn_sin(ang);
		cs = turn_sin(ang + 16'h4000);
		al = ud * cs - uq * sn;
		be = ud * sn + uq * cs;
		s3a = al * 56756;
		code = 3'b000;
		if (be > 0) code[0] = 1'b1;
		if (s3a - be * 32768 > 0) code[1] = 1'b1;
		if (-s3a - be * 32768 > 0) code[2] = 1'b1;
		case (code)
			3'd1: sec = 3'd2;
			3'd2: sec = 3'd6;
			3'd3: sec = 3'd1;
			3'd4: sec = 3'd4;
			3'd5: sec = 3'd3;
			3'd6: sec = 3'd5;
			default: sec = 3'd1;
		endcase
		n1 = al * st[sec] * 32768 - be * ct[sec] * 56756;
		n2 = be * ct[sec-1] * 56756 - al * st[sec-1] * 32768;
		dv = (bus_volts == 0 ? 1 : bus_volts) << 31;
		if (n1 + n2 > dv) dv = n1 + n2;
		t1 = time_ratio(n1, dv);
		t2 = time_ratio(n2, dv);
		t0 = (t1 + t2 >= 32768) ? 0 : 32768 - t1 - t2;
		h = t0 >>> 1;
		case (sec)
			3'd1: begin da = h; db = h + t1; dc = h + t1 + t2; end
			3'd2: begin da = h + t2; db = h; dc = h + t1 + t2; end
			3'd3: begin da = h + t1 + t2; db = h; dc = h + t1; end
			3'd4: begin da = h + t1 + t2; db = h + t2; dc = h; end
			3'd5: begin da = h + t1; db = h + t1 + t2; dc = h; end
			default: begin da = h; db = h + t1 + t2; dc = h + t2; end
		endcase
		o.compare_a = duty_to_compare(da);
		o.compare_b = duty_to_compare(db);
		o.compare_c = duty_to_compare(dc);
		o.sector_number = sec;
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Driver: one request from the queue at a time, random gaps between
	int req_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_compares.push_back(predict_compares(req_data));
			end
			if (req_valid && !req_ready) begin
				// hold the request until accepted
			end else if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap <= req_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				req_data <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_gap <= gap_len();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls on the response side, in-order field checks
	int stall_cnt = 0;
	always @(posedge clk) begin
		svpwm_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_compares.size() == 0) begin
					report("unexpected response", rsp_data, '0);
				end else begin
					want = expected_compares.pop_front();
					if (rsp_data.compare_a !== want.compare_a)
						report("compare_a", rsp_data, want);
					if (rsp_data.compare_b !== want.compare_b)
						report("compare_b", rsp_data, want);
					if (rsp_data.compare_c !== want.compare_c)
						report("compare_c", rsp_data, want);
					if (rsp_data.sector_number !== want.sector_number)
						report("sector_number", rsp_data, want);
				end
			end
			if (stall_cnt > 0) begin
				rsp_ready <= 1'b0;
				stall_cnt <= stall_cnt - 1;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_cnt <= gap_len();
			end
		end
	end

	function automatic svpwm_pkg::req_t rand_req();
		svpwm_pkg::req_t r;
		int p;
		r.rotor_angle = 16'($urandom);
		p = $urandom_range(0, 9);
		if (p < 6) begin
			// moderate voltages keep the vector inside the hexagon most times
			r.torque_voltage = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
			r.direct_voltage = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
		end else begin
			r.torque_voltage = 16'($urandom);
			r.direct_voltage = 16'($urandom);
		end
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_compares.size() > 0)
			@(posedge clk);
		repeat (svpwm_pkg::LAT + 4) @(posedge clk);
	endtask

	// Write one register while idle; step past the edge after the drop so
	// back-to-back writes never drive the same signal twice in one step
	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == svpwm_pkg::CFG_SUPPLY) bus_volts = val[14:0];
		else period = val;
		@(posedge clk);
	endtask

	task automatic push_req(input logic signed [15:0] q, input logic signed [15:0] d,
			input logic [15:0] a);
		svpwm_pkg::req_t r;
		r.torque_voltage = q;
		r.direct_voltage = d;
		r.rotor_angle = a;
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic [15:0] supplies[6];
		logic [15:0] periods[6];
		supplies = '{16'd12288, 16'd1, 16'd32767, 16'd0, 16'd3000, 16'd20000};
		periods = '{16'd1000, 16'd65535, 16'd1, 16'd0, 16'd4999, 16'd250};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: field extremes, each sector, sign-code edge at zero voltage
		push_req(16'sd0, 16'sd0, 16'd0);
		push_req(16'sh7fff, 16'sh7fff, 16'hffff);
		push_req(16'sh8000, 16'sh8000, 16'd0);
		push_req(16'sh8000, 16'sd0, 16'h4000);
		push_req(16'sh7fff, 16'sh8000, 16'h8000);
		push_req(-16'sd1, 16'sd1, 16'hc000);
		for (int s = 0; s < 12; s++)
			push_req(16'sd4000, 16'sd0, 16'(s * 5461 + 2730));
		push_req(16'sd0, 16'sd5000, 16'h2000);
		push_req(16'sd12288, 16'sd0, 16'h1555);
		push_req(16'sd100, -16'sd100, 16'h5555);
		wait_idle();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(svpwm_pkg::CFG_SUPPLY, supplies[ph]);
			write_reg(svpwm_pkg::CFG_PERIOD, periods[ph]);
			for (int i = 0; i < 225; i++) pending_reqs.push_back(rand_req());
			wait_idle();
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (errors == 0 && expected_compares.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ svpwm_seven_segment_modulator_top.f @@
sv/svpwm_pkg.sv
sv/svpwm_sin.sv
sv/svpwm_div.sv
sv/svpwm_seven_segment_modulator_top.sv
sv/svpwm_chk.sv
tb/sv/svpwm_seven_segment_modulator_top_tb.sv
